// File: rtl/hdlcd_pkg.sv
// ----------------------------------------------------------------------------
// hdlcd_pkg
// Types, constants and the CRC-16/X-25 byte update for the HDLC frame decoder.
// ----------------------------------------------------------------------------
package hdlcd_pkg;

	localparam logic [7:0]  FLAG_BYTE = 8'h7E;
	localparam logic [7:0]  ESC_BYTE  = 8'h7D;
	localparam logic [7:0]  ESC_XOR   = 8'h20;
	localparam logic [15:0] CRC_POLY  = 16'h8408;
	localparam logic [15:0] CRC_INIT  = 16'hFFFF;
	localparam logic [15:0] POS_MAX   = 16'hFFFF;
	// a buffer needs at least four bytes, so the final byte sits at position three or later
	localparam logic [15:0] MIN_FRAME = 16'd4;

	typedef enum logic [5:0] {
		PH_AWAIT    = 6'b000001,
		PH_BADSTART = 6'b000010,
		PH_DECODE   = 6'b000100,
		PH_ESCAPE   = 6'b001000,
		PH_STOPPED  = 6'b010000,
		PH_OVERRUN  = 6'b100000
	} phase_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_INVALID = 2'd1,
		ST_ESCAPE  = 2'd2,
		ST_CRC     = 2'd3
	} status_t;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       end_of_buffer;
	} rx_item_t;

	typedef struct packed {
		logic        is_status;
		logic [7:0]  payload_byte;
		logic [1:0]  frame_status;
		logic [15:0] payload_length;
	} res_item_t;

	function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

// File: rtl/hdlcd_frame_state.sv
// ----------------------------------------------------------------------------
// hdlcd_frame_state
// Frame phase, unstuffing, two-byte CRC hold, running CRC and final status.
// ----------------------------------------------------------------------------
module hdlcd_frame_state
	import hdlcd_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  rx_item_t  item,
	input  logic      take,
	output logic      emit,
	output res_item_t res
);

	phase_t      phase_q;
	logic [15:0] pos_q;
	logic [7:0]  hold_q [2];
	logic [1:0]  hold_cnt_q;
	logic [15:0] crc_q;
	logic [15:0] pay_cnt_q;

	phase_t      phase_d;
	logic        push;
	logic [7:0]  push_byte;
	logic        shift_out;
	logic [16:0] decoded;
	logic [15:0] calc_crc;
	logic [15:0] rcvd_crc;

	assign decoded  = {1'b0, pay_cnt_q} + {15'd0, hold_cnt_q};
	assign calc_crc = ~crc_q;
	assign rcvd_crc = {hold_q[1], hold_q[0]};
	assign shift_out = push && (hold_cnt_q == 2'd2);

	always_comb begin
		phase_d   = phase_q;
		push      = 1'b0;
		push_byte = item.rx_byte;
		if (pos_q == POS_MAX) begin
			phase_d = PH_OVERRUN;
		end else begin
			case (phase_q)
				PH_AWAIT: begin
					phase_d = (item.rx_byte == FLAG_BYTE) ? PH_DECODE : PH_BADSTART;
				end
				PH_DECODE: begin
					if (item.rx_byte == ESC_BYTE) begin
						phase_d = PH_ESCAPE;
					end else if (item.rx_byte == FLAG_BYTE) begin
						phase_d = PH_STOPPED;
					end else begin
						push = 1'b1;
					end
				end
				PH_ESCAPE: begin
					push      = 1'b1;
					push_byte = item.rx_byte ^ ESC_XOR;
					phase_d   = PH_DECODE;
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		res = '0;
		emit = 1'b0;
		if (item.end_of_buffer) begin
			emit          = 1'b1;
			res.is_status = 1'b1;
			if (phase_q == PH_OVERRUN || pos_q == POS_MAX) begin
				res.frame_status = ST_INVALID;
			end else if (pos_q < MIN_FRAME - 16'd1 || phase_q == PH_BADSTART ||
					phase_q == PH_AWAIT || item.rx_byte != FLAG_BYTE) begin
				res.frame_status = ST_INVALID;
			end else if (phase_q == PH_ESCAPE) begin
				res.frame_status   = ST_ESCAPE;
				res.payload_length = decoded[15:0];
			end else if (decoded < 17'd2) begin
				res.frame_status   = ST_INVALID;
				res.payload_length = decoded[15:0];
			end else begin
				res.frame_status   = (rcvd_crc == calc_crc) ? ST_OK : ST_CRC;
				res.payload_length = pay_cnt_q;
			end
		end else if (shift_out) begin
			emit             = 1'b1;
			res.payload_byte = hold_q[0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_AWAIT;
			pos_q      <= '0;
			hold_cnt_q <= '0;
			crc_q      <= CRC_INIT;
			pay_cnt_q  <= '0;
		end else if (take) begin
			if (item.end_of_buffer) begin
				phase_q    <= PH_AWAIT;
				pos_q      <= '0;
				hold_cnt_q <= '0;
				crc_q      <= CRC_INIT;
				pay_cnt_q  <= '0;
			end else begin
				phase_q <= phase_d;
				if (pos_q != POS_MAX) begin
					pos_q <= pos_q + 16'd1;
				end
				if (shift_out) begin
					crc_q     <= crc_update(crc_q, hold_q[0]);
					pay_cnt_q <= pay_cnt_q + 16'd1;
				end else if (push) begin
					hold_cnt_q <= hold_cnt_q + 2'd1;
				end
			end
		end
	end

	// held bytes carry no reset
	always_ff @(posedge clk) begin
		if (take && !item.end_of_buffer && push) begin
			if (shift_out) begin
				hold_q[0] <= hold_q[1];
				hold_q[1] <= push_byte;
			end else if (hold_cnt_q == 2'd0) begin
				hold_q[0] <= push_byte;
			end else begin
				hold_q[1] <= push_byte;
			end
		end
	end

endmodule

// File: rtl/hdlc_frame_decoder_core.sv
// ----------------------------------------------------------------------------
// hdlc_frame_decoder_core
// HDLC frame decoder with byte unstuffing and CRC-16/X-25 check.
// ----------------------------------------------------------------------------
// Usage: raw buffer bytes enter on in_data (rx_byte, end_of_buffer) under
// in_valid/in_stall; a request is taken at an edge with in_valid high and
// in_stall low. Results leave on out_data under out_valid/out_stall: one
// payload byte per decoded byte once the two-byte CRC hold is full, and one
// status result for the byte marked end_of_buffer.
// Throughput: one byte per cycle while in_stall is low. Each request is
// registered, then decoded by a single level of logic into the result
// register, which drives out_data.
// When the receiver stalls, the result register holds and the request
// register can still take one more byte; requests that make no result keep
// flowing. in_stall then rises only once a result-making byte is waiting.
// Reset clears the frame state to await a start flag and empties both
// registers; the status result also returns the frame state to that point.
// ----------------------------------------------------------------------------
module hdlc_frame_decoder_core
	import hdlcd_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  rx_item_t  in_data,
	output logic      out_valid,
	input  logic      out_stall,
	output res_item_t out_data
);

	logic      valid_s1;
	rx_item_t  item_s1;
	logic      out_valid_q;
	res_item_t out_q;
	res_item_t res;
	logic      take;
	logic      emit;
	logic      advance;

	assign advance  = !out_valid_q || !out_stall;
	assign take     = valid_s1 && (!emit || advance);
	assign in_stall = valid_s1 && !take;

	hdlcd_frame_state u_state (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_s1),
		.take   (take),
		.emit   (emit),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			item_s1 <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take && emit) begin
			out_valid_q <= 1'b1;
		end else if (advance) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && emit) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_stall_needs_request: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1)
		else $error("input stalled with an empty request register");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(take && emit) |-> advance)
		else $error("result register loaded while a stalled result waits");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(out_data)))
		else $error("stalled result changed");

	a_payload_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_data.is_status) |->
			(out_data.frame_status == ST_OK && out_data.payload_length == 16'd0))
		else $error("payload result carries status fields");

	a_status_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.is_status) |-> (out_data.payload_byte == 8'd0))
		else $error("status result carries a payload byte");

endmodule
